// File: src/etcd_pkg.sv
// ----------------------------------------------------------------------------
// etcd_pkg: shared types and constants for the epoch to civil date converter
// Reciprocal constants, queue sizing, item records and the month offset table.
// ----------------------------------------------------------------------------
package etcd_pkg;

  // Widths of the stream payloads
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 104;

  // Queue between classifier and arithmetic pipeline
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Number of payload stages in the arithmetic pipeline, output register excluded
  localparam int BACK_STAGES = 9;

  // First second of year 10000 (day 2932897 after the epoch); at or above it
  // the date cannot be shown
  localparam logic [62:0] LIMIT_SECS = 63'd253402300800;

  localparam logic [37:0] SECS_PER_DAY  = 38'd86400;
  localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
  localparam logic [21:0] DAYS_TO_EPOCH = 22'd719468;
  localparam logic [21:0] DAYS_PER_ERA  = 22'd146097;
  localparam logic [13:0] YEAR_LIMIT    = 14'd9999;

  // Rounded-up reciprocals; each is exact over the operand range it meets
  // (seconds/128 by 675, 2^41)
  localparam logic [31:0] RECIP_DAY  = 32'd3257812231;
  // (seconds/16 by 225, 2^22)
  localparam logic [14:0] RECIP_HOUR = 15'd18642;
  // (seconds/4 by 15, 2^14)
  localparam logic [10:0] RECIP_MIN  = 11'd1093;
  // (day number by 146097, 2^39)
  localparam logic [21:0] RECIP_ERA  = 22'd3762951;
  // (day of era/4 by 365, 2^24)
  localparam logic [15:0] RECIP_1460 = 16'd45965;
  // (day count by 365, 2^26)
  localparam logic [17:0] RECIP_YEAR = 18'd183860;
  // (5*doy+2 by 153, 2^18)
  localparam logic [10:0] RECIP_MP   = 11'd1714;

  // Item as classified by the front end
  typedef struct packed {
    logic        over;
    logic [62:0] clamped;
  } item_t;

  // Working record carried down the arithmetic pipeline
  typedef struct packed {
    logic        over;
    logic [62:0] clamped;
    logic [21:0] days;
    logic [16:0] secs;
    logic [21:0] z;
    logic [4:0]  hour;
    logic [4:0]  era;
    logic [11:0] rem;
    logic [17:0] doe;
    logic [5:0]  minute;
    logic [6:0]  q1460;
    logic [2:0]  c36524;
    logic        c146096;
    logic [17:0] n;
    logic [8:0]  yoe;
    logic [8:0]  doy;
    logic [13:0] ybase;
    logic [3:0]  mp;
  } work_t;

  // Days before the first of each month, counted from the first of March
  function automatic logic [8:0] mp_offset(input logic [3:0] mp);
    logic [8:0] off;
    case (mp)
      4'd0:    off = 9'd0;
      4'd1:    off = 9'd31;
      4'd2:    off = 9'd61;
      4'd3:    off = 9'd92;
      4'd4:    off = 9'd122;
      4'd5:    off = 9'd153;
      4'd6:    off = 9'd184;
      4'd7:    off = 9'd214;
      4'd8:    off = 9'd245;
      4'd9:    off = 9'd275;
      4'd10:   off = 9'd306;
      4'd11:   off = 9'd337;
      default: off = 9'd0;
    endcase
    return off;
  endfunction

endpackage

// File: src/etcd_front.sv
// ----------------------------------------------------------------------------
// etcd_front: input classifier
// Clamps negative timestamps to zero and flags those beyond year 9999.
// ----------------------------------------------------------------------------
module etcd_front (
  input  logic [etcd_pkg::IN_DATA_W-1:0] epoch_seconds,
  output etcd_pkg::item_t                item
);
  import etcd_pkg::*;

  logic [62:0] clamped;

  // Drop negative values to zero
  assign clamped = epoch_seconds[63] ? 63'd0 : epoch_seconds[62:0];

  // Flag timestamps whose year cannot be shown
  assign item.clamped = clamped;
  assign item.over    = (clamped >= LIMIT_SECS);

endmodule

// File: src/etcd_queue.sv
// ----------------------------------------------------------------------------
// etcd_queue: short item queue
// Holds classified items so that the front and back stall independently.
// ----------------------------------------------------------------------------
module etcd_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  input  etcd_pkg::item_t push_item,
  output logic            push_ready,
  output logic            head_valid,
  output etcd_pkg::item_t head_item,
  input  logic            pop
);
  import etcd_pkg::*;

  item_t               entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                push;

  assign push_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign push       = push_valid && push_ready;
  assign head_valid = (count != '0);
  assign head_item  = entries[rd_ptr];

  // Store the incoming item
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  // Never pop an empty queue
  assert property (@(posedge clk) disable iff (rst) pop |-> count != '0)
    else $error("queue popped while empty");

  // Occupancy tracks a lone push
  assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + QCNT_W'(1))
    else $error("queue count lost a push");

endmodule

// File: src/etcd_back.sv
// ----------------------------------------------------------------------------
// etcd_back: arithmetic pipeline
// Splits seconds into day, hour and minute and converts the day number to a
// civil date; the output register feeds the result stream.
// ----------------------------------------------------------------------------
module etcd_back (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            head_valid,
  input  etcd_pkg::item_t                 head_item,
  output logic                            pop,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [etcd_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic                            m_tuser
);
  import etcd_pkg::*;

  work_t             stg [BACK_STAGES];
  work_t             nxt [BACK_STAGES];
  logic [BACK_STAGES-1:0] vld;
  logic              en;

  // Products, each registered before the next use
  logic [62:0] prod_day;
  logic [27:0] prod_hour;
  logic [43:0] prod_era;
  logic [20:0] prod_min;
  logic [31:0] prod_1460;
  logic [35:0] prod_yoe;
  logic [21:0] prod_mp;

  // Intermediate differences
  logic [37:0] secs_full;
  logic [16:0] rem_full;
  logic [21:0] doe_full;
  logic [17:0] yday_base;
  logic [17:0] doy_full;
  logic [1:0]  c100;
  logic [10:0] mp_arg;

  // Final stage results
  logic [8:0]  day_full;
  logic [3:0]  month;
  logic [13:0] year;

  // Output register
  logic        out_vld;
  logic        out_over;
  logic [13:0] out_year;
  logic [3:0]  out_month;
  logic [4:0]  out_day;
  logic [4:0]  out_hour;
  logic [5:0]  out_minute;
  logic [62:0] out_clamped;

  // Whole pipeline moves when the output register is free or taken
  assign en  = !out_vld || m_tready;
  assign pop = head_valid && en;

  assign prod_day  = 63'(head_item.clamped[37:7]) * 63'(RECIP_DAY);
  assign secs_full = stg[0].clamped[37:0] - 38'(stg[0].days) * SECS_PER_DAY;
  assign prod_hour = 28'(stg[1].secs[16:4]) * 28'(RECIP_HOUR);
  assign prod_era  = 44'(stg[1].z) * 44'(RECIP_ERA);
  assign rem_full  = stg[2].secs - 17'(stg[2].hour) * SECS_PER_HOUR;
  assign doe_full  = stg[2].z - 22'(stg[2].era) * DAYS_PER_ERA;
  assign prod_min  = 21'(stg[3].rem[11:2]) * 21'(RECIP_MIN);
  assign prod_1460 = 32'(stg[3].doe[17:2]) * 32'(RECIP_1460);
  assign prod_yoe  = 36'(stg[5].n) * 36'(RECIP_YEAR);

  // Century count within the era, years 0..399
  assign c100 = 2'(stg[6].yoe >= 9'd100) + 2'(stg[6].yoe >= 9'd200)
              + 2'(stg[6].yoe >= 9'd300);
  assign yday_base = 18'(stg[6].yoe) * 18'd365 + 18'(stg[6].yoe[8:2]) - 18'(c100);
  assign doy_full  = stg[6].doe - yday_base;

  assign mp_arg  = 11'(stg[7].doy) * 11'd5 + 11'd2;
  assign prod_mp = 22'(mp_arg) * 22'(RECIP_MP);

  // Build each stage's record from the one before
  always_comb begin
    for (int i = 1; i < BACK_STAGES; i++) begin
      nxt[i] = stg[i-1];
    end
    nxt[0]         = '0;
    nxt[0].over    = head_item.over;
    nxt[0].clamped = head_item.clamped;
    nxt[0].days    = prod_day[62:41];

    nxt[1].secs = secs_full[16:0];
    nxt[1].z    = stg[0].days + DAYS_TO_EPOCH;

    nxt[2].hour = prod_hour[26:22];
    nxt[2].era  = prod_era[43:39];

    nxt[3].rem = rem_full[11:0];
    nxt[3].doe = doe_full[17:0];

    nxt[4].minute  = prod_min[19:14];
    nxt[4].q1460   = prod_1460[30:24];
    nxt[4].c36524  = 3'(stg[3].doe >= 18'd36524) + 3'(stg[3].doe >= 18'd73048)
                   + 3'(stg[3].doe >= 18'd109572) + 3'(stg[3].doe >= 18'd146096);
    nxt[4].c146096 = (stg[3].doe == 18'd146096);

    nxt[5].n = stg[4].doe - 18'(stg[4].q1460) + 18'(stg[4].c36524)
             - 18'(stg[4].c146096);

    nxt[6].yoe = prod_yoe[34:26];

    nxt[7].doy   = doy_full[8:0];
    nxt[7].ybase = 14'(stg[6].era) * 14'd400 + 14'(stg[6].yoe);

    nxt[8].mp = prod_mp[21:18];
  end

  // Month, day and year from the shifted month index
  always_comb begin
    day_full = stg[8].doy - mp_offset(stg[8].mp) + 9'd1;
    if (stg[8].mp < 4'd10) begin
      month = stg[8].mp + 4'd3;
    end else begin
      month = stg[8].mp - 4'd9;
    end
    year = stg[8].ybase + 14'(month <= 4'd2);
  end

  // Pipeline payload
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < BACK_STAGES; i++) begin
        stg[i] <= nxt[i];
      end
    end
  end

  // Pipeline occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[BACK_STAGES-2:0], head_valid};
    end
  end

  // Output register; zero the date fields when the year cannot be shown
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= vld[BACK_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_over    <= stg[8].over;
      out_clamped <= stg[8].clamped;
      if (stg[8].over) begin
        out_year   <= '0;
        out_month  <= '0;
        out_day    <= '0;
        out_hour   <= '0;
        out_minute <= '0;
      end else begin
        out_year   <= year;
        out_month  <= month;
        out_day    <= day_full[4:0];
        out_hour   <= stg[8].hour;
        out_minute <= stg[8].minute;
      end
    end
  end

  assign m_tvalid = out_vld;
  assign m_tuser  = out_over;
  assign m_tdata  = {7'd0, out_clamped, out_minute, out_hour, out_day, out_month,
                     out_year};

  // Fallback results carry no date
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> m_tdata[33:0] == '0)
    else $error("date fields set on a fallback result");

  // Shown dates have a real month and day
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (out_month >= 4'd1 && out_month <= 4'd12 &&
                                out_day >= 5'd1))
    else $error("month or day out of range");

  // Shown years stay within four digits
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> out_year <= YEAR_LIMIT)
    else $error("year beyond limit without fallback");

endmodule

// File: src/epoch_to_civil_datetime_top.sv
// Converts signed 64-bit Unix timestamps (seconds, UTC) into proleptic
// Gregorian year, month, day, hour and minute. Negative timestamps are read as
// zero. When the year would pass 9999 the tuser flag is set, the date fields
// are zero and the clamped seconds are still given for raw display. One item is
// accepted per clock while the result stream takes one per clock; each item
// passes through the four-entry input queue and then the arithmetic pipeline
// (nine stages plus the output register). With the result side stalled, up to
// four more items are taken into the queue before s_tready falls.
// ----------------------------------------------------------------------------
// epoch_to_civil_datetime_top: Unix timestamp to civil date and time
// Front classifier, item queue and arithmetic pipeline on stream ports.
// ----------------------------------------------------------------------------
module epoch_to_civil_datetime_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // [63:0] epoch_seconds
  input  logic [etcd_pkg::IN_DATA_W-1:0]  s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [13:0] year, [17:14] month, [22:18] day_of_month, [27:23] hour,
  // [33:28] minute, [96:34] clamped_seconds, [103:97] zero
  output logic [etcd_pkg::OUT_DATA_W-1:0] m_tdata,
  // [0] out_of_range
  output logic                            m_tuser
);
  import etcd_pkg::*;

  item_t front_item;
  item_t head_item;
  logic  head_valid;
  logic  pop;

  // Classify incoming timestamps
  etcd_front u_front (
    .epoch_seconds (s_tdata),
    .item          (front_item)
  );

  // Buffer classified items
  etcd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (s_tvalid),
    .push_item  (front_item),
    .push_ready (s_tready),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop)
  );

  // Convert and deliver
  etcd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser)
  );

endmodule
